>>> rtl/pimt_pkg.sv
// Package with types, constants and status codes of the page interval merge table.
`timescale 1ns / 1ps
package pimt_pkg;
    localparam int TABLE_DEPTH_DEF = 32;
    localparam int ADDR_BITS_DEF   = 48;
    localparam int SHIFT_BITS      = 5;
    localparam int SHIFT_MAX       = 20;
    localparam logic [4:0] SHIFT_RESET = 5'd12;

    localparam logic [1:0] OP_MERGE  = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_ZERO     = 2'd3;

    typedef struct packed {
        logic [1:0]               op;
        logic [ADDR_BITS_DEF-1:0] addr;
        logic [ADDR_BITS_DEF-1:0] length;
    } req_t;

    typedef struct packed {
        logic [1:0]               status;
        logic [ADDR_BITS_DEF-1:0] region_base;
        logic [ADDR_BITS_DEF:0]   region_size;
    } rsp_t;
endpackage

>>> rtl/pimt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module pimt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

>>> rtl/page_interval_merge_table_unit.sv
// Top level of the page interval merge table: request sequencer over the region memory.
`timescale 1ns / 1ps
// A request passes from acceptance to result in order: the align state page-aligns the
// range, then one scan pass reads every slot of the region memory in turn through its
// single read port, then the write state writes the merged region back. Valid marks are
// flip-flops cleared at reset; the memory needs no clearing.
// Merge unions every stored region that overlaps or touches the page-aligned range into
// the lowest free slot. The result is held in an output register; the next request is
// taken once it has been delivered.
module page_interval_merge_table_unit #(
    parameter int TABLE_DEPTH = pimt_pkg::TABLE_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [pimt_pkg::SHIFT_BITS-1:0] cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  pimt_pkg::req_t                  s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output pimt_pkg::rsp_t                  m_data
);
    import pimt_pkg::*;

    localparam int ADDR_BITS = ADDR_BITS_DEF;
    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int AW = ADDR_BITS + 1;
    localparam int EFF_MAX = (SHIFT_MAX < ADDR_BITS) ? SHIFT_MAX : ADDR_BITS;
    localparam logic [AW-1:0] TOP = {1'b1, {ADDR_BITS{1'b0}}};

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ALIGN = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_WRITE = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0]            state_reg, state_next;
    logic [SHIFT_BITS-1:0] shift_reg;
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic [TABLE_DEPTH-1:0] hit_reg, hit_next;
    logic [1:0]            op_reg;
    logic [AW-1:0]         addr_reg, len_reg;
    logic [AW-1:0]         start_reg, end_reg, lo_reg, hi_reg;
    logic [CW-1:0]         rd_cnt_reg;
    logic [IW-1:0]         chk_idx_reg;
    logic                  chk_vld_reg;
    logic                  found_reg;
    logic [AW-1:0]         fb_reg, fs_reg;
    logic [IW-1:0]         fidx_reg;
    rsp_t                  rsp_reg;

    logic [ADDR_BITS-1:0]  rd_base;
    logic [AW-1:0]         rd_size;
    logic                  wr_en;
    logic [IW-1:0]         wr_addr;

    pimt_ram #(.WIDTH(ADDR_BITS), .DEPTH(TABLE_DEPTH)) u_base (
        .aclk(aclk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(lo_reg[ADDR_BITS-1:0]),
        .rd_addr(rd_cnt_reg[IW-1:0]), .rd_data(rd_base));
    pimt_ram #(.WIDTH(AW), .DEPTH(TABLE_DEPTH)) u_size (
        .aclk(aclk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(hi_reg - lo_reg),
        .rd_addr(rd_cnt_reg[IW-1:0]), .rd_data(rd_size));

    logic [4:0]    eff_shift;
    logic [AW-1:0] pmask, start_c, sum_c, end_c;
    logic [AW-1:0] eb, ee;
    logic          overlap, contains;
    logic [IW-1:0] free_idx;
    logic          free_any;
    logic          merge_go;

    // A merge of zero length leaves the table untouched.
    assign merge_go = (op_reg == OP_MERGE) && (len_reg != '0);

    always_comb begin
        eff_shift = (shift_reg > 5'(EFF_MAX)) ? 5'(EFF_MAX) : shift_reg;
        pmask   = (AW'(1) << eff_shift) - AW'(1);
        start_c = addr_reg & ~pmask;
        sum_c   = addr_reg + len_reg;
        end_c   = (sum_c + pmask) & ~pmask;
        if (end_c > TOP || (sum_c + pmask) < sum_c) begin
            end_c = TOP;
        end
        eb = {1'b0, rd_base};
        ee = eb + rd_size;
        overlap  = chk_vld_reg && valid_reg[chk_idx_reg] && eb <= end_reg && ee >= start_reg;
        contains = chk_vld_reg && valid_reg[chk_idx_reg] && eb <= addr_reg
                   && (addr_reg - eb) < rd_size;
    end

    // Lowest free slot after absorbed entries are cleared.
    always_comb begin
        free_idx = '0;
        free_any = 1'b0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
            if (!(valid_reg[i] && !hit_reg[i])) begin
                free_idx = IW'(i);
                free_any = 1'b1;
            end
        end
    end

    assign wr_en   = (state_reg == S_WRITE) && merge_go && free_any;
    assign wr_addr = free_idx;
    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_OUT);
    assign m_data  = rsp_reg;

    always_comb begin
        state_next = state_reg;
        valid_next = valid_reg;
        hit_next   = hit_reg;
        unique case (state_reg)
            S_IDLE:  if (s_valid) state_next = S_ALIGN;
            S_ALIGN: state_next = S_SCAN;
            S_SCAN: begin
                if (overlap && merge_go) hit_next[chk_idx_reg] = 1'b1;
                if (chk_vld_reg && chk_idx_reg == IW'(TABLE_DEPTH - 1)) state_next = S_WRITE;
            end
            S_WRITE: begin
                state_next = S_OUT;
                if (merge_go) begin
                    if (|hit_reg || free_any) begin
                        valid_next = (valid_reg & ~hit_reg) | (TABLE_DEPTH'(1) << free_idx);
                    end
                end else if (op_reg == OP_REMOVE && found_reg) begin
                    valid_next[fidx_reg] = 1'b0;
                end
            end
            S_OUT:   if (m_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            shift_reg <= SHIFT_RESET;
            valid_reg <= '0;
            hit_reg   <= '0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            hit_reg   <= (state_reg == S_IDLE) ? '0 : hit_next;
            if (cfg_we) shift_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: begin
                op_reg      <= s_data.op;
                addr_reg    <= {1'b0, s_data.addr[ADDR_BITS-1:0]};
                len_reg     <= {1'b0, s_data.length[ADDR_BITS-1:0]};
                rd_cnt_reg  <= '0;
                chk_vld_reg <= 1'b0;
                found_reg   <= 1'b0;
            end
            S_ALIGN: begin
                start_reg  <= start_c;
                end_reg    <= end_c;
                lo_reg     <= start_c;
                hi_reg     <= end_c;
                rd_cnt_reg <= CW'(1);
                chk_idx_reg <= '0;
                chk_vld_reg <= 1'b1;
            end
            S_SCAN: begin
                // Read address runs one slot ahead of the entry being checked.
                rd_cnt_reg  <= rd_cnt_reg + CW'(1);
                chk_idx_reg <= rd_cnt_reg[IW-1:0];
                if (overlap) begin
                    if (eb < lo_reg) lo_reg <= eb;
                    if (ee > hi_reg) hi_reg <= ee;
                end
                if (contains && !found_reg) begin
                    found_reg <= 1'b1;
                    fb_reg    <= eb;
                    fs_reg    <= rd_size;
                    fidx_reg  <= chk_idx_reg;
                end
            end
            S_WRITE: begin
                rsp_reg.region_base <= '0;
                rsp_reg.region_size <= '0;
                rsp_reg.status      <= ST_NOTFOUND;
                if (op_reg == OP_MERGE) begin
                    if (len_reg == '0) begin
                        rsp_reg.status <= ST_ZERO;
                    end else begin
                        rsp_reg.status      <= (|hit_reg || free_any) ? ST_OK : ST_FULL;
                        rsp_reg.region_base <= ADDR_BITS'(lo_reg);
                        rsp_reg.region_size <= AW'(hi_reg - lo_reg);
                    end
                end else if ((op_reg == OP_REMOVE || op_reg == OP_LOOKUP) && found_reg) begin
                    rsp_reg.status      <= ST_OK;
                    rsp_reg.region_base <= ADDR_BITS'(fb_reg);
                    rsp_reg.region_size <= AW'(fs_reg);
                end
            end
            default: ;
        endcase
    end
endmodule

>>> tb/pimt_checker.sv
// Checker that predicts the region table behavior and compares every result word.
`timescale 1ns / 1ps
module pimt_checker
    import pimt_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    cfg_we,
    input  logic [SHIFT_BITS-1:0] cfg_wdata,
    input  logic    s_valid,
    input  logic    s_ready,
    input  req_t    s_data,
    input  logic    m_valid,
    input  logic    m_ready,
    input  rsp_t    m_data,
    output int      fail_count,
    output int      pending,
    output int      result_count
);
    localparam int DEPTH = TABLE_DEPTH_DEF;
    localparam logic [48:0] TOP = 49'h1_0000_0000_0000;

    logic [4:0]  shift_reg;
    logic        reg_valid [DEPTH];
    logic [48:0] reg_base [DEPTH];
    logic [48:0] reg_size [DEPTH];
    rsp_t        expected_results [$];

    function automatic rsp_t predict_region(req_t r);
        rsp_t o;
        int s, slot;
        logic [48:0] page, start, stop, lo, hi, ee;
        logic [63:0] stop_sum;
        logic absorbed;
        o = '0;
        o.status = ST_NOTFOUND;
        if (r.op == OP_MERGE) begin
            if (r.length == 0) begin
                o.status = ST_ZERO;
                return o;
            end
            s = (shift_reg > SHIFT_MAX) ? SHIFT_MAX : shift_reg;
            page = 49'd1 << s;
            start = {1'b0, r.addr} & ~(page - 1);
            // The rounded-up end can pass 49 bits before it is clamped to the top.
            stop_sum = (64'(r.addr) + 64'(r.length) + 64'(page) - 64'd1)
                       & ~(64'(page) - 64'd1);
            stop = (stop_sum > 64'(TOP)) ? TOP : stop_sum[48:0];
            lo = start;
            hi = stop;
            absorbed = 0;
            for (int i = 0; i < DEPTH; i++) begin
                ee = reg_base[i] + reg_size[i];
                if (reg_valid[i] && reg_base[i] <= stop && ee >= start) begin
                    if (reg_base[i] < lo) lo = reg_base[i];
                    if (ee > hi) hi = ee;
                    absorbed = 1;
                    reg_valid[i] = 0;
                end
            end
            slot = -1;
            for (int i = DEPTH - 1; i >= 0; i--) if (!reg_valid[i]) slot = i;
            if (slot < 0) begin
                o.status = ST_FULL;
                o.region_base = start[47:0];
                o.region_size = stop - start;
                return o;
            end
            reg_valid[slot] = 1;
            reg_base[slot] = lo;
            reg_size[slot] = hi - lo;
            o.status = ST_OK;
            o.region_base = lo[47:0];
            o.region_size = hi - lo;
        end else if (r.op == OP_REMOVE || r.op == OP_LOOKUP) begin
            for (int i = 0; i < DEPTH; i++) begin
                if (reg_valid[i] && reg_base[i] <= {1'b0, r.addr} &&
                    {1'b0, r.addr} - reg_base[i] < reg_size[i]) begin
                    o.status = ST_OK;
                    o.region_base = reg_base[i][47:0];
                    o.region_size = reg_size[i];
                    if (r.op == OP_REMOVE) reg_valid[i] = 0;
                    break;
                end
            end
        end
        return o;
    endfunction

    always @(posedge aclk) begin
        rsp_t want;
        if (!aresetn) begin
            shift_reg <= SHIFT_RESET;
            for (int i = 0; i < DEPTH; i++) reg_valid[i] = 0;
            expected_results.delete();
            fail_count <= 0;
            result_count <= 0;
        end else begin
            if (cfg_we) shift_reg <= cfg_wdata;
            if (s_valid && s_ready) expected_results.push_back(predict_region(s_data));
            if (m_valid && m_ready) begin
                result_count <= result_count + 1;
                if (expected_results.size() == 0) begin
                    $display("%t: unexpected result word %h", $realtime, m_data);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (want.status != m_data.status ||
                        want.region_base != m_data.region_base ||
                        want.region_size != m_data.region_size) begin
                        $display("%t: mismatch expected st=%0d base=%h size=%h, got st=%0d base=%h size=%h",
                                 $realtime, want.status, want.region_base, want.region_size,
                                 m_data.status, m_data.region_base, m_data.region_size);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
        pending = expected_results.size();
    end
endmodule

>>> tb/tb_page_interval_merge_table_unit.sv
// Testbench top: stimulus, handshake idling and the final verdict for the region table.
`timescale 1ns / 1ps
module tb_page_interval_merge_table_unit;
    import pimt_pkg::*;

    logic aclk = 0;
    logic aresetn = 0;
    logic cfg_we = 0;
    logic [SHIFT_BITS-1:0] cfg_wdata = '0;
    logic s_valid = 0;
    logic s_ready;
    req_t s_data = '0;
    logic m_valid;
    logic m_ready = 0;
    rsp_t m_data;
    int fail_count, pending, result_count;
    int cycle_count = 0;
    int sent = 0;
    bit hold_off = 0;
    bit hold_done = 0;

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    page_interval_merge_table_unit u_top (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    pimt_checker u_checker (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .fail_count(fail_count), .pending(pending), .result_count(result_count)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 1500000) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver: a random wait before each word, plus one long hold-off on request.
    initial begin
        int gap;
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                m_ready <= 0;
                repeat (400) @(negedge aclk);
                hold_off = 0;
                hold_done = 1;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
            if (gap > 0) begin
                m_ready <= 0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    // Valid stays up across back-to-back words; it drops only before a gap.
    task automatic send_word(logic [1:0] op, logic [47:0] addr, logic [47:0] len,
                             int gap);
        if (gap > 0) begin
            s_valid <= 0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1;
        s_data <= '{op: op, addr: addr, length: len};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        sent++;
    endtask

    task automatic drain_and_idle();
        s_valid <= 0;
        while (pending != 0) @(negedge aclk);
        repeat (60) @(negedge aclk);
    endtask

    task automatic write_shift(logic [4:0] v);
        cfg_wdata <= v;
        cfg_we <= 1;
        @(negedge aclk);
        cfg_we <= 0;
    endtask

    function automatic logic [47:0] rand_addr(int mode);
        logic [47:0] a;
        a = {$urandom, $urandom};
        // Mostly a small window so regions collide, merge and get found.
        if (mode < 7) a = a & 48'h0000_00FF_FFFF;
        return a;
    endfunction

    task automatic random_phase(int count, logic [4:0] shift);
        int kind;
        logic [1:0] op;
        logic [47:0] a, len;
        write_shift(shift);
        for (int i = 0; i < count; i++) begin
            kind = $urandom_range(0, 9);
            a = rand_addr($urandom_range(0, 9));
            len = (kind == 9) ? {$urandom, $urandom} :
                  (kind == 8) ? 48'd0 : 48'($urandom_range(1, 40000));
            op = (kind < 5) ? OP_MERGE : (kind < 7) ? OP_LOOKUP :
                 (kind < 9) ? OP_REMOVE : 2'($urandom_range(0, 3));
            send_word(op, a, len, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19));
        end
        drain_and_idle();
    endtask

    initial begin
        repeat (3) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // Directed: zero length, extremes, range past the top, misses, op 3.
        send_word(OP_MERGE, 48'h1000, 48'd0, 0);
        send_word(OP_LOOKUP, 48'h0, 48'd0, 0);
        send_word(OP_MERGE, 48'h1234, 48'h10, 1);
        send_word(OP_MERGE, 48'h2000, 48'h1, 0);
        send_word(OP_MERGE, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 0);
        send_word(OP_LOOKUP, 48'h1FFF, 48'hFFFF_FFFF_FFFF, 2);
        send_word(OP_LOOKUP, 48'hFFFF_FFFF_FFFF, 48'd0, 0);
        send_word(OP_REMOVE, 48'h1000, 48'd0, 0);
        send_word(OP_REMOVE, 48'h1000, 48'd0, 0);
        send_word(2'd3, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 0);
        send_word(OP_MERGE, 48'h0, 48'hFFFF_FFFF_FFFF, 0);
        send_word(OP_REMOVE, 48'h5555_5555_5555, 48'd0, 0);
        drain_and_idle();

        // Fill the table with separated pages, then overflow it; the receiver stalls.
        write_shift(5'd31);
        hold_off = 1;
        for (int i = 0; i < 34; i++)
            send_word(OP_MERGE, 48'(i) << 22, 48'd1, 0);
        // One merge that spans everything frees all but one slot.
        send_word(OP_MERGE, 48'h0, 48'hFFFF_FFFF_FFFF, 0);
        send_word(OP_LOOKUP, 48'h123_4567, 48'd0, 0);
        send_word(OP_REMOVE, 48'h0, 48'd0, 0);
        s_valid <= 0;
        wait (hold_done);
        drain_and_idle();

        write_shift(5'd0);
        random_phase(400, 5'd0);
        random_phase(400, 5'd12);
        random_phase(300, 5'd20);
        random_phase(350, 5'($urandom_range(0, 31)));

        $display("covered %0d request words over page shifts 0, 12, 20, 31 and random,", sent);
        $display("including table overflow, wide merges and a long result stall");
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

>>> page_interval_merge_table_unit.f
rtl/pimt_pkg.sv
rtl/pimt_ram.sv
rtl/page_interval_merge_table_unit.sv
tb/pimt_checker.sv
tb/tb_page_interval_merge_table_unit.sv
